// File: rtl/pea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator package
// Shared widths, payload types and saturation limits of the aggregator.
// ----------------------------------------------------------------------------
package pea_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 264;

  // Divider: quotient magnitudes below 2**15 are worked out one bit a step.
  localparam int DIV_STEPS = 15;
  localparam int DIV_CNT_W = 4;

  // Saturation limits.
  localparam logic signed [31:0] ESUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] ESUM_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] WSUM_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] WSUM_MIN = 48'sh8000_0000_0000;
  localparam logic signed [15:0] PSD_MAX  = 16'sh7fff;
  localparam logic signed [15:0] PSD_MIN  = 16'sh8000;

  // One detector pulse as it enters the block.
  typedef struct packed {
    logic [31:0]        event_number;
    logic [8:0]         segment;
    logic signed [23:0] energy;
    logic [47:0]        pulse_time;
    logic signed [15:0] z;
    logic signed [15:0] psd;
  } pulse_t;

  // Accumulated state of one closed group, before the PSD division.
  typedef struct packed {
    logic [31:0]        event_number;
    logic signed [31:0] energy_sum;
    logic signed [47:0] weighted_sum;
    logic [47:0]        start_time;
    logic signed [23:0] best_energy;
    logic [8:0]         best_segment;
    logic signed [15:0] best_z;
    logic signed [15:0] best_psd;
  } group_rec_t;

  // Push request from the front end into the record queue.
  typedef struct packed {
    logic       valid;
    group_rec_t rec;
  } rec_push_t;

endpackage

// File: rtl/pea_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator front end
// Takes pulses, forms the energy times PSD product and keeps the running
// accumulators of the open group; pushes a record when the group closes.
// ----------------------------------------------------------------------------
module pea_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pea_pkg::pulse_t    in_pulse,
  input  logic               in_last,
  input  logic               q_full,
  output pea_pkg::rec_push_t q_push
);
  import pea_pkg::*;

  // Input stage: registered pulse and its product.
  logic               a_valid_r;
  logic               a_last_r;
  pulse_t             a_pulse_r;
  logic signed [39:0] a_prod_r;

  // Open group accumulators.
  logic               open_r;
  logic [31:0]        cur_ev_r;
  logic signed [31:0] esum_r;
  logic signed [47:0] wsum_r;
  logic [47:0]        start_r;
  logic signed [23:0] best_e_r;
  logic [8:0]         best_seg_r;
  logic signed [15:0] best_z_r;
  logic signed [15:0] best_psd_r;

  logic               a_load;
  logic               ev_change;
  logic               closing;
  logic               advance;
  logic [32:0]        esum_wide;
  logic [48:0]        wsum_wide;
  logic signed [31:0] esum_nxt;
  logic signed [47:0] wsum_nxt;

  // Handshake and closing decision.
  always_comb begin
    ev_change = a_pulse_r.event_number != cur_ev_r;
    closing   = a_valid_r && open_r && (a_last_r || ev_change);
    advance   = a_valid_r && !(closing && q_full);
    in_ready  = !a_valid_r || advance;
    a_load    = in_valid && in_ready;
  end

  // Saturating accumulation of energy and weighted PSD.
  always_comb begin
    esum_wide = {esum_r[31], esum_r} + {{9{a_pulse_r.energy[23]}}, a_pulse_r.energy};
    if (esum_wide[32] != esum_wide[31]) begin
      esum_nxt = esum_wide[32] ? ESUM_MIN : ESUM_MAX;
    end else begin
      esum_nxt = esum_wide[31:0];
    end
    wsum_wide = {wsum_r[47], wsum_r} + {{9{a_prod_r[39]}}, a_prod_r};
    if (wsum_wide[48] != wsum_wide[47]) begin
      wsum_nxt = wsum_wide[48] ? WSUM_MIN : WSUM_MAX;
    end else begin
      wsum_nxt = wsum_wide[47:0];
    end
  end

  // The record leaves with the state as it stands before this item.
  always_comb begin
    q_push.valid            = closing && !q_full;
    q_push.rec.event_number = cur_ev_r;
    q_push.rec.energy_sum   = esum_r;
    q_push.rec.weighted_sum = wsum_r;
    q_push.rec.start_time   = start_r;
    q_push.rec.best_energy  = best_e_r;
    q_push.rec.best_segment = best_seg_r;
    q_push.rec.best_z       = best_z_r;
    q_push.rec.best_psd     = best_psd_r;
  end

  // Input stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_load) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  // Input stage payload and product.
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_last_r  <= in_last;
      a_pulse_r <= in_pulse;
      a_prod_r  <= 40'($signed(in_pulse.energy)) * 40'($signed(in_pulse.psd));
    end
  end

  // Group open flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (advance) begin
      open_r <= !a_last_r;
    end
  end

  // Accumulators: a new group starts from its first pulse, later pulses add in.
  always_ff @(posedge clk) begin
    if (advance && !a_last_r) begin
      if (!open_r || ev_change) begin
        cur_ev_r   <= a_pulse_r.event_number;
        esum_r     <= 32'($signed(a_pulse_r.energy));
        wsum_r     <= 48'(a_prod_r);
        start_r    <= a_pulse_r.pulse_time;
        best_e_r   <= a_pulse_r.energy;
        best_seg_r <= a_pulse_r.segment;
        best_z_r   <= a_pulse_r.z;
        best_psd_r <= a_pulse_r.psd;
      end else begin
        esum_r <= esum_nxt;
        wsum_r <= wsum_nxt;
        // Strictly greater, so the earliest of equal maxima stays.
        if ($signed(a_pulse_r.energy) > best_e_r) begin
          best_e_r   <= a_pulse_r.energy;
          best_seg_r <= a_pulse_r.segment;
          best_z_r   <= a_pulse_r.z;
          best_psd_r <= a_pulse_r.psd;
        end
      end
    end
  end

endmodule

// File: rtl/pea_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator record queue
// Short first-in first-out buffer of closed group records between the
// front end and the division back end.
// ----------------------------------------------------------------------------
module pea_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pea_pkg::rec_push_t  push,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop_ready,
  output pea_pkg::group_rec_t pop_rec
);
  import pea_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_rec_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full      = count_r == CNT_W'(DEPTH);
    pop_valid = count_r != '0;
    pop_rec   = mem_r[rd_ptr_r];
    do_push   = push.valid && !full;
    do_pop    = pop_valid && pop_ready;
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/pea_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator back end
// Divides the weighted PSD sum by the energy sum, one quotient bit a cycle,
// and holds the finished event record in the output register.
// ----------------------------------------------------------------------------
module pea_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  pea_pkg::group_rec_t             pop_rec,
  input  logic [63:0]                     run_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pea_pkg::OUT_TDATA_W-1:0] out_data,
  output logic                            out_user
);
  import pea_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             st_r;
  logic [1:0]             st_nxt;
  group_rec_t             rec_r;
  logic                   zero_r;
  logic                   sat_r;
  logic                   neg_r;
  logic [47:0]            rem_r;
  logic [44:0]            dsh_r;
  logic [DIV_STEPS-1:0]   quo_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_user_r;

  logic [47:0]            mag;
  logic                   den_pos;
  logic                   sat_hit;
  logic                   ge;
  logic                   out_free;
  logic signed [15:0]     psd_res;

  // Set-up of one division: magnitude of the dividend and the overflow test.
  always_comb begin
    mag       = pop_rec.weighted_sum[47] ? 48'(-pop_rec.weighted_sum)
                                         : 48'(pop_rec.weighted_sum);
    den_pos   = !pop_rec.energy_sum[31] && (pop_rec.energy_sum != '0);
    sat_hit   = mag >= {2'b00, pop_rec.energy_sum[30:0], 15'b0};
    ge        = rem_r >= {3'b000, dsh_r};
    out_free  = !out_valid_r || out_ready;
    pop_ready = st_r == ST_IDLE;
  end

  // Final PSD: zero for a non-positive total, clamped, or the signed quotient.
  always_comb begin
    if (zero_r) begin
      psd_res = '0;
    end else if (sat_r) begin
      psd_res = neg_r ? PSD_MIN : PSD_MAX;
    end else if (neg_r) begin
      psd_res = -$signed({1'b0, quo_r});
    end else begin
      psd_res = $signed({1'b0, quo_r});
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (pop_valid) begin
          st_nxt = (!den_pos || sat_hit) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Divider datapath: restoring division, quotient built from its top bit.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && pop_valid) begin
      rec_r  <= pop_rec;
      zero_r <= !den_pos;
      sat_r  <= den_pos && sat_hit;
      neg_r  <= pop_rec.weighted_sum[47];
      rem_r  <= mag;
      dsh_r  <= {pop_rec.energy_sum[30:0], 14'b0};
      quo_r  <= '0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (st_r == ST_DIV) begin
      if (ge) begin
        rem_r <= rem_r - {3'b000, dsh_r};
      end
      quo_r <= {quo_r[DIV_STEPS-2:0], ge};
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register: record payload.
  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && out_free) begin
      out_data_r <= {7'b0, rec_r.best_psd, rec_r.best_z, rec_r.best_segment,
                     rec_r.best_energy, run_start, rec_r.start_time, psd_res,
                     rec_r.energy_sum, rec_r.event_number};
      out_user_r <= !zero_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

endmodule

// File: rtl/pulse_event_aggregator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator
// Builds one event record from each run of consecutive detector pulses that
// share an event number.
// ----------------------------------------------------------------------------
// Usage:
//   Pulses enter on the in_ stream, one per cycle when nothing backs up.
//   in_tlast marks an end-of-run item: it flushes the open group and its
//   pulse fields are ignored. A pulse with a new event number closes the
//   open group; the record of that group leaves on the out_ stream.
//   cfg_wr_en loads the run start stamp copied into every record; write it
//   only while the block is idle.
// Timing:
//   The item that closes a group passes the input stage; the record then goes
//   through the queue, the divider (one quotient bit per cycle) and the output
//   register. Records with a non-positive total or a clamped PSD skip the
//   division.
//   The divider takes one record at a time; up to QUEUE_DEPTH closed records
//   wait in the queue, and once it is full in_tready drops when a further
//   group closes, until room frees up.
// Reset clears the open group, the queue and the output valid flag; the run
// start stamp resets to zero. A stalled out_tready holds the record while
// the front end keeps taking pulses until the queue is full and a group closes.
// ----------------------------------------------------------------------------
module pulse_event_aggregator_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // event_number[31:0], segment[40:32], pulse_energy[64:41],
  // pulse_time[112:65], pulse_z[128:113], pulse_psd[144:129], zero fill
  input  logic [pea_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // end_of_run
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_event_number[31:0], total_energy[63:32], weighted_psd[79:64],
  // first_time[127:80], run_start[191:128], max_energy[215:192],
  // max_segment[224:216], max_z[240:225], max_psd[256:241], zero fill
  output logic [pea_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,  // psd_valid
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [63:0]                     cfg_wr_data // run_start_time
);
  import pea_pkg::*;

  logic [63:0] run_start_r;
  pulse_t      in_pulse;
  rec_push_t   q_push;
  logic        q_full;
  logic        q_pop_valid;
  logic        q_pop_ready;
  group_rec_t  q_pop_rec;

  // Run start register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_start_r <= '0;
    end else if (cfg_wr_en) begin
      run_start_r <= cfg_wr_data;
    end
  end

  // Unpack the incoming pulse.
  always_comb begin
    in_pulse.event_number = in_tdata[31:0];
    in_pulse.segment      = in_tdata[40:32];
    in_pulse.energy       = in_tdata[64:41];
    in_pulse.pulse_time   = in_tdata[112:65];
    in_pulse.z            = in_tdata[128:113];
    in_pulse.psd          = in_tdata[144:129];
  end

  pea_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_pulse (in_pulse),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  pea_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .full      (q_full),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_rec   (q_pop_rec)
  );

  pea_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_rec   (q_pop_rec),
    .run_start (run_start_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

// File: rtl/pea_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator checker
// Port-level checks on the record stream, bound to the top level.
// ----------------------------------------------------------------------------
module pea_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pea_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import pea_pkg::*;

  // No record is offered in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("record offered straight after reset");

  // A stalled record stays in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("record changed while stalled");

  // The PSD valid flag follows the sign of the total energy.
  a_valid_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == (!out_tdata[63] && (out_tdata[63:32] != 32'd0)))
    else $error("psd_valid disagrees with total energy");

  // Without a positive total the weighted PSD reads zero.
  a_psd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[79:64] == 16'd0)
    else $error("weighted PSD not zero for a non-positive total");

endmodule

bind pulse_event_aggregator_unit pea_checker u_pea_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse event aggregator testbench
// Feeds pulse items and end-of-run items into the aggregator, with random gaps
// on the input and random stalls on the output. Every event record is
// predicted from the accepted items or given by the script, and checked field by field, in order.
// A short scripted sequence covers the extremes, ties, PSD clamping and flush
// behaviour. Random groups, stray pulses and long saturating groups follow,
// under several run start settings.
// ----------------------------------------------------------------------------
module tb;
  import pea_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item accepted on either side
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 610;
  localparam int MAX_REPORTS    = 10;
  localparam int N_DIRECTED     = 21;

  localparam logic signed [23:0] ENERGY_MAX = 24'sh7f_ffff;
  localparam logic signed [23:0] ENERGY_MIN = 24'sh80_0000;
  localparam logic [63:0]        ALL_ONES   = 64'hffff_ffff_ffff_ffff;

  // One event record as it leaves the block; psd_valid travels on out_tuser.
  typedef struct packed {
    logic [31:0]        event_no;
    logic signed [31:0] total_energy;
    logic signed [15:0] weighted_psd;
    logic               psd_valid;
    logic [47:0]        first_time;
    logic [63:0]        run_start;
    logic signed [23:0] max_energy;
    logic [8:0]         max_segment;
    logic signed [15:0] max_z;
    logic signed [15:0] max_psd;
  } event_rec_t;

  // One scripted item; where lit is set, want replaces the predicted record.
  typedef struct packed {
    logic       eor;
    pulse_t     pulse;
    logic       lit;
    event_rec_t want;
  } stim_row_t;

  // Scripted sequence, run with the run start register at all ones.
  localparam stim_row_t DIRECTED_ITEMS [N_DIRECTED] = '{
    // End of run with nothing open: no record.
    '{1'b1, '{32'h1234_5678, 9'd3, 24'sd77, 48'd9, 16'sd1, 16'sd2}, 1'b0, '0},
    // First pulse after reset, every field at its top value.
    '{1'b0, '{32'hffff_ffff, 9'd511, ENERGY_MAX, 48'hffff_ffff_ffff, PSD_MAX, PSD_MAX},
      1'b0, '0},
    // Flush of a single-pulse group.
    '{1'b1, '{32'h0, 9'd0, 24'sd0, 48'd0, 16'sd0, 16'sd0}, 1'b1,
      '{32'hffff_ffff, 32'sd8388607, 16'sh7fff, 1'b1, 48'hffff_ffff_ffff, ALL_ONES,
        ENERGY_MAX, 9'd511, 16'sh7fff, 16'sh7fff}},
    // Second flush finds no open group.
    '{1'b1, '{32'hffff_ffff, 9'd511, ENERGY_MAX, 48'd1, 16'sd5, 16'sd5}, 1'b0, '0},
    // First pulse after a flush, every field at its bottom value.
    '{1'b0, '{32'h0, 9'd0, ENERGY_MIN, 48'd0, PSD_MIN, PSD_MIN}, 1'b0, '0},
    // New event closes a negative group: no valid PSD.
    '{1'b0, '{32'd1, 9'd5, 24'sd0, 48'd100, 16'sd0, 16'sd0}, 1'b1,
      '{32'd0, 32'shff80_0000, 16'sd0, 1'b0, 48'd0, ALL_ONES,
        ENERGY_MIN, 9'd0, 16'sh8000, 16'sh8000}},
    // Closes a zero-energy group: no valid PSD.
    '{1'b0, '{32'd2, 9'd10, 24'sd4096, 48'd200, 16'sd10, 16'sd1000}, 1'b1,
      '{32'd1, 32'sd0, 16'sd0, 1'b0, 48'd100, ALL_ONES,
        24'sd0, 9'd5, 16'sd0, 16'sd0}},
    // Tie with the current maximum, then a new maximum, then a negative pulse.
    '{1'b0, '{32'd2, 9'd11, 24'sd4096, 48'd210, 16'sd20, 16'sd2000}, 1'b0, '0},
    '{1'b0, '{32'd2, 9'd12, 24'sd8192, 48'd220, 16'sd30, -16'sd3000}, 1'b0, '0},
    '{1'b0, '{32'd2, 9'd13, -24'sd4096, 48'd230, 16'sd40, 16'sd5000}, 1'b0, '0},
    // Mean PSD of the closed group is not a whole number: truncation.
    '{1'b0, '{32'd3, 9'd300, 24'sd100, 48'd300, -16'sd5, 16'sd7}, 1'b0, '0},
    '{1'b0, '{32'd3, 9'd301, -24'sd30, 48'd310, -16'sd6, 16'sd3}, 1'b0, '0},
    // Tiny positive total with a huge weighted sum: PSD clamps high.
    '{1'b0, '{32'd4, 9'd100, ENERGY_MAX, 48'd400, 16'sd44, PSD_MAX}, 1'b0, '0},
    '{1'b0, '{32'd4, 9'd101, 24'sh80_0002, 48'd410, 16'sd45, PSD_MIN}, 1'b0, '0},
    '{1'b0, '{32'd5, 9'd200, ENERGY_MAX, 48'd500, PSD_MIN, PSD_MIN}, 1'b1,
      '{32'd4, 32'sd1, 16'sh7fff, 1'b1, 48'd400, ALL_ONES,
        ENERGY_MAX, 9'd100, 16'sd44, 16'sh7fff}},
    // And the mirror case: PSD clamps low.
    '{1'b0, '{32'd5, 9'd201, 24'sh80_0002, 48'd510, PSD_MAX, PSD_MAX}, 1'b0, '0},
    '{1'b1, '{32'd9, 9'd1, 24'sd1, 48'd1, 16'sd1, 16'sd1}, 1'b1,
      '{32'd5, 32'sd1, 16'sh8000, 1'b1, 48'd500, ALL_ONES,
        ENERGY_MAX, 9'd200, 16'sh8000, 16'sh8000}},
    // Same event number again after a flush opens a fresh group.
    '{1'b0, '{32'd5, 9'd7, 24'sd1, 48'd600, 16'sd0, -16'sd1}, 1'b0, '0},
    '{1'b0, '{32'd5, 9'd8, 24'sd2, 48'd610, 16'sd1, 16'sd9}, 1'b0, '0},
    '{1'b0, '{32'h8000_0000, 9'd9, 24'sd3, 48'd620, 16'sd2, -16'sd9}, 1'b0, '0},
    '{1'b1, '{32'h0, 9'd0, 24'sd0, 48'd0, 16'sd0, 16'sd0}, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_wr_en;
  logic [63:0]            cfg_wr_data;

  // Predicted state of the aggregator.
  logic [63:0]        run_start_reg = '0;
  logic               grp_open      = 1'b0;
  logic [31:0]        grp_event     = '0;
  longint             e_sum         = 0;
  longint             w_sum         = 0;
  logic [47:0]        grp_start     = '0;
  logic signed [23:0] top_energy    = '0;
  logic [8:0]         top_segment   = '0;
  logic signed [15:0] top_z         = '0;
  logic signed [15:0] top_psd       = '0;

  event_rec_t pending_records[$];
  int         mismatches   = 0;
  int         items_sent   = 0;
  int         quiet_cycles = 0;
  bit         calm         = 1'b0;

  pulse_event_aggregator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Record of the open group, with the PSD division done here.
  function automatic event_rec_t close_group();
    event_rec_t r;
    longint     q;
    r = '0;
    r.event_no     = grp_event;
    r.total_energy = e_sum[31:0];
    if (e_sum > 0) begin
      q = sat(w_sum / e_sum, longint'(PSD_MIN), longint'(PSD_MAX));
      r.weighted_psd = q[15:0];
      r.psd_valid    = 1'b1;
    end
    r.first_time  = grp_start;
    r.run_start   = run_start_reg;
    r.max_energy  = top_energy;
    r.max_segment = top_segment;
    r.max_z       = top_z;
    r.max_psd     = top_psd;
    return r;
  endfunction

  // Advances the predicted state by one accepted item; returns 1 with a record.
  function automatic bit aggregate_item(input logic eor, input pulse_t p,
                                        output event_rec_t r);
    longint e;
    longint prod;
    bit     emitted;
    e       = longint'($signed(p.energy));
    prod    = e * longint'($signed(p.psd));
    emitted = 1'b0;
    r       = '0;
    if (eor) begin
      if (grp_open) begin
        r        = close_group();
        emitted  = 1'b1;
        grp_open = 1'b0;
      end
    end else if (!grp_open || p.event_number != grp_event) begin
      if (grp_open) begin
        r       = close_group();
        emitted = 1'b1;
      end
      grp_open    = 1'b1;
      grp_event   = p.event_number;
      e_sum       = e;
      w_sum       = prod;
      grp_start   = p.pulse_time;
      top_energy  = p.energy;
      top_segment = p.segment;
      top_z       = p.z;
      top_psd     = p.psd;
    end else begin
      e_sum = sat(e_sum + e, longint'(ESUM_MIN), longint'(ESUM_MAX));
      w_sum = sat(w_sum + prod, longint'(WSUM_MIN), longint'(WSUM_MAX));
      // The earliest pulse keeps the maximum on a tie.
      if (p.energy > top_energy) begin
        top_energy  = p.energy;
        top_segment = p.segment;
        top_z       = p.z;
        top_psd     = p.psd;
      end
    end
    return emitted;
  endfunction

  // Offers one item, with random idle cycles before it outside the calm stretch, and predicts its record.
  task automatic send_item(input logic eor, input pulse_t p, input logic lit,
                           input event_rec_t want);
    event_rec_t r;
    if (!calm) begin
      while ($urandom_range(0, 99) < 33) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tlast  <= eor;
    in_tdata  <= IN_TDATA_W'({p.psd, p.z, p.pulse_time, p.energy, p.segment,
                              p.event_number});
    do @(posedge clk); while (!in_tready);
    items_sent++;
    calm = (items_sent >= 300 && items_sent < 600);
    if (aggregate_item(eor, p, r)) begin
      pending_records.insert(pending_records.size(), lit ? want : r);
    end
  endtask

  // Random pulse of the given event; now and then it repeats an earlier energy.
  function automatic pulse_t random_pulse(input logic [31:0] ev,
                                          input logic signed [23:0] last_energy);
    pulse_t p;
    int     mode;
    p.event_number = ev;
    p.segment      = 9'($urandom());
    p.pulse_time   = 48'({$urandom(), $urandom()});
    p.z            = 16'($urandom());
    p.psd          = 16'($urandom());
    mode = $urandom_range(0, 99);
    if (mode < 45) begin
      p.energy = 24'($urandom());
    end else if (mode < 85) begin
      p.energy = 24'($urandom_range(1, 40000));
    end else begin
      p.energy = last_energy;
    end
    return p;
  endfunction

  // One random sequence: mostly a well-formed group, else a stray pulse or a burst of flushes.
  task automatic random_sequence();
    int                 kind;
    int                 n;
    logic [31:0]        ev;
    logic signed [23:0] last_energy;
    pulse_t             p;
    kind        = $urandom_range(0, 99);
    last_energy = '0;
    if (kind < 72) begin
      n  = $urandom_range(1, 6);
      ev = $urandom();
      repeat (n) begin
        p           = random_pulse(ev, last_energy);
        last_energy = p.energy;
        send_item(1'b0, p, 1'b0, '0);
      end
      if ($urandom_range(0, 99) < 25) begin
        send_item(1'b1, random_pulse($urandom(), '0), 1'b0, '0);
      end
    end else if (kind < 86) begin
      // A small set of event numbers, so strays sometimes join the open group.
      send_item(1'b0, random_pulse(32'($urandom_range(0, 3)), '0), 1'b0, '0);
    end else begin
      // Burst of flushes; all after the first find no open group.
      repeat ($urandom_range(1, 3)) begin
        send_item(1'b1, random_pulse($urandom(), '0), 1'b0, '0);
      end
    end
  endtask

  // Long group of near-extreme pulses to drive the accumulators into saturation.
  task automatic send_long_group(input int n, input bit negative);
    logic [31:0] ev;
    pulse_t      p;
    bit          psd_high;
    ev       = $urandom();
    psd_high = 1'($urandom());
    repeat (n) begin
      p = random_pulse(ev, '0);
      if (negative) begin
        p.energy = ENERGY_MIN + 24'($urandom_range(0, 3));
      end else begin
        p.energy = ENERGY_MAX - 24'($urandom_range(0, 3));
        p.psd    = psd_high ? PSD_MAX - 16'($urandom_range(0, 3))
                            : PSD_MIN + 16'($urandom_range(0, 3));
      end
      send_item(1'b0, p, 1'b0, '0);
    end
  endtask

  // Waits for the block to go idle, then loads the run start stamp.
  task automatic settle_and_write(input logic [63:0] value);
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    run_start_reg = value;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("tb: %s mismatch at %0t: expected %0h, got %0h", name, $time, want, got);
      end
    end
  endtask

  // Output readiness: random stalls, none during the calm stretch.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 33);
  end

  // Record checker and watchdog.
  always @(posedge clk) begin
    event_rec_t got;
    event_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.event_no     = out_tdata[31:0];
      got.total_energy = out_tdata[63:32];
      got.weighted_psd = out_tdata[79:64];
      got.psd_valid    = out_tuser;
      got.first_time   = out_tdata[127:80];
      got.run_start    = out_tdata[191:128];
      got.max_energy   = out_tdata[215:192];
      got.max_segment  = out_tdata[224:216];
      got.max_z        = out_tdata[240:225];
      got.max_psd      = out_tdata[256:241];
      if (pending_records.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb: unexpected record for event %0h at %0t", got.event_no, $time);
        end
      end else begin
        want = pending_records.pop_front();
        check_field("event_number", want.event_no, got.event_no);
        check_field("total_energy", want.total_energy, got.total_energy);
        check_field("weighted_psd", want.weighted_psd, got.weighted_psd);
        check_field("psd_valid", want.psd_valid, got.psd_valid);
        check_field("first_time", want.first_time, got.first_time);
        check_field("run_start", want.run_start, got.run_start);
        check_field("max_energy", want.max_energy, got.max_energy);
        check_field("max_segment", want.max_segment, got.max_segment);
        check_field("max_z", want.max_z, got.max_z);
        check_field("max_psd", want.max_psd, got.max_psd);
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Main sequence: reset, scripted items, then three random phases.
  initial begin
    int ph;
    int stop_at;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    settle_and_write(ALL_ONES);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_item(DIRECTED_ITEMS[i].eor, DIRECTED_ITEMS[i].pulse,
                DIRECTED_ITEMS[i].lit, DIRECTED_ITEMS[i].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      settle_and_write((ph == 0) ? 64'd0 : {$urandom(), $urandom()});
      stop_at = items_sent + PHASE_ITEMS;
      // Weighted sum saturates after about 512 extreme pulses, energy sum after 256.
      if (ph == 1) send_long_group(540, 1'b0);
      if (ph == 2) send_long_group(270, 1'b1);
      while (items_sent < stop_at) random_sequence();
    end

    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: pulse_event_aggregator_unit.f
rtl/pea_pkg.sv
rtl/pea_front.sv
rtl/pea_queue.sv
rtl/pea_back.sv
rtl/pulse_event_aggregator_unit.sv
rtl/pea_checker.sv
bench/tb.sv
